// ===== rtl/aes_pkg.sv =====
package aes_pkg;

  localparam int unsigned MaxRoundsDefault = 14;
  localparam int unsigned MinRounds = 10;

  localparam logic [1:0] OP_KEY = 2'd0;
  localparam logic [1:0] OP_ENC = 2'd1;
  localparam logic [1:0] OP_DEC = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  // command from controller to datapath
  typedef struct packed {
    logic load;      // capture block
    logic key0;      // apply the first key group only
    logic dec;       // direction of the item in flight
    logic round;     // apply one round with the key group read this cycle
    logic last;      // final round: no mix column step
    logic store;     // move the finished block to the output register
  } aes_cmd_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] sbox_fwd(input logic [7:0] x);
    logic [7:0] s [256];
    s = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox_fwd = s[x];
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] y);
    logic [7:0] s [256];
    s = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    sbox_inv = s[y];
  endfunction

endpackage

// ===== rtl/aes_datapath.sv =====
module aes_datapath import aes_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = MaxRoundsDefault
) (
  input  logic         clk_i,
  input  aes_cmd_t     cmd_i,
  input  logic         key_we_i,
  input  logic [$clog2(4*(MAX_ROUNDS+1))-1:0] key_waddr_i,
  input  logic [31:0]  key_wdata_i,
  input  logic [$clog2(MAX_ROUNDS+1)-1:0] key_raddr_i,
  input  logic [127:0] block_i,
  output logic [127:0] res_o
);

  localparam int unsigned Groups = MAX_ROUNDS + 1;
  localparam int unsigned GW = $clog2(Groups);

  // key table, one 128-bit group per row, one word written per beat
  logic [31:0]  mem_q [Groups][4];
  logic [127:0] rk_q;
  logic [127:0] state_q, state_d;
  logic [127:0] res_q;

  always_ff @(posedge clk_i) begin
    if (key_we_i) mem_q[key_waddr_i[GW+1:2]][key_waddr_i[1:0]] <= key_wdata_i;
  end

  // registered read: the controller issues the address in the cycle before use
  always_ff @(posedge clk_i) begin
    rk_q <= {mem_q[key_raddr_i][0], mem_q[key_raddr_i][1],
             mem_q[key_raddr_i][2], mem_q[key_raddr_i][3]};
  end

  // byte b of state sits at bits 127-8b
  function automatic logic [7:0] bget(input logic [127:0] s, input int b);
    bget = s[127-8*b -: 8];
  endfunction

  logic [127:0] fwd, inv, mixf, mixi, invk;

  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fwd[127-8*(c*4+r) -: 8] = sbox_fwd(bget(state_q, ((c + r) % 4) * 4 + r));
        inv[127-8*(((c + r) % 4) * 4 + r) -: 8] = sbox_inv(bget(state_q, c*4 + r));
      end
    end
    invk = inv ^ rk_q;
    for (int c = 0; c < 4; c++) begin
      a0 = bget(fwd, c*4); a1 = bget(fwd, c*4+1);
      a2 = bget(fwd, c*4+2); a3 = bget(fwd, c*4+3);
      mixf[127-8*(c*4)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      mixf[127-8*(c*4+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      mixf[127-8*(c*4+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      mixf[127-8*(c*4+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      a0 = bget(invk, c*4); a1 = bget(invk, c*4+1);
      a2 = bget(invk, c*4+2); a3 = bget(invk, c*4+3);
      mixi[127-8*(c*4)   -: 8] = gmul(a0,8'h0e)^gmul(a1,8'h0b)^gmul(a2,8'h0d)^gmul(a3,8'h09);
      mixi[127-8*(c*4+1) -: 8] = gmul(a0,8'h09)^gmul(a1,8'h0e)^gmul(a2,8'h0b)^gmul(a3,8'h0d);
      mixi[127-8*(c*4+2) -: 8] = gmul(a0,8'h0d)^gmul(a1,8'h09)^gmul(a2,8'h0e)^gmul(a3,8'h0b);
      mixi[127-8*(c*4+3) -: 8] = gmul(a0,8'h0b)^gmul(a1,8'h0d)^gmul(a2,8'h09)^gmul(a3,8'h0e);
    end
  end

  // select the next state: load, first key addition or round result
  always_comb begin
    state_d = state_q;
    if (cmd_i.load) state_d = block_i;
    else if (cmd_i.key0) state_d = state_q ^ rk_q;
    else if (cmd_i.round) begin
      if (!cmd_i.dec) state_d = (cmd_i.last ? fwd : mixf) ^ rk_q;
      else state_d = cmd_i.last ? invk : mixi;
    end
  end

  // first key addition happens in the cycle after load, with key group 0 or nr
  always_ff @(posedge clk_i) state_q <= state_d;

  // hold the finished block for the output channel
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) res_q <= state_q;
  end

  assign res_o = res_q;

endmodule

// ===== rtl/aes_ctrl.sv =====
module aes_ctrl import aes_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = MaxRoundsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [3:0] round_count_i,
  output aes_cmd_t   cmd_o,
  output logic [$clog2(MAX_ROUNDS+1)-1:0] key_raddr_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  localparam int unsigned GW = $clog2(MAX_ROUNDS+1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_KEY0 = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]    st_q, st_d;
  logic          dec_q, dec_d;
  logic [GW-1:0] rnd_q, rnd_d, nr_q, nr_d;
  logic [GW-1:0] nr_c;
  logic          start;
  logic          out_valid_q, out_valid_d;
  logic          out_free;

  // clamp round count
  always_comb begin
    if (round_count_i < 4'(MinRounds)) nr_c = GW'(MinRounds);
    else if (round_count_i > 4'(MAX_ROUNDS)) nr_c = GW'(MAX_ROUNDS);
    else nr_c = GW'(round_count_i);
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign start       = in_valid_i && in_ready_o && (op_i == OP_ENC || op_i == OP_DEC);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    st_d  = st_q;
    dec_d = dec_q;
    rnd_d = rnd_q;
    nr_d  = nr_q;
    cmd_o = '0;
    key_raddr_o = '0;
    unique case (st_q)
      S_IDLE: begin
        cmd_o.load = start;
        key_raddr_o = (op_i == OP_DEC) ? nr_c : '0;
        if (start) begin
          st_d  = S_KEY0;
          dec_d = (op_i == OP_DEC);
          nr_d  = nr_c;
          rnd_d = GW'(1);
        end
      end
      S_KEY0: begin
        cmd_o.key0 = 1'b1;
        key_raddr_o = dec_q ? nr_q - rnd_q : rnd_q;
        st_d = S_RUN;
      end
      S_RUN: begin
        cmd_o.round = 1'b1;
        cmd_o.last  = (rnd_q == nr_q);
        key_raddr_o = dec_q ? nr_q - rnd_q - GW'(1) : rnd_q + GW'(1);
        if (rnd_q == nr_q) st_d = S_OUT;
        else rnd_d = rnd_q + GW'(1);
      end
      S_OUT: begin
        // hand the block over once the output register is free
        if (out_free) begin
          cmd_o.store = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
    cmd_o.dec = dec_q;

    // output register valid: drop on accept, set on store
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.store) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      dec_q       <= 1'b0;
      rnd_q       <= '0;
      nr_q        <= GW'(MinRounds);
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      dec_q       <= dec_d;
      rnd_q       <= rnd_d;
      nr_q        <= nr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/aes_block_cipher_top.sv =====
// Channel  Direction  tdata fields (low bit up)             tuser
// s_axis   in         key_index, key_word, block_hi, lo     op
// m_axis   out        result_hi, result_lo                  -
// apb      cfg        round_count at address 0
// An encrypt or decrypt item passes through a first key addition, one round
// step per round (round_count clamped to 10..MAX_ROUNDS) and a store step
// that moves the block to the output register. The next item is accepted
// only after the previous one is stored, as there is a single round unit
// and one registered key-table read per cycle. Key writes finish in the
// accept cycle. The engine waits only while the output register holds a
// stalled beat. Reset clears control and the output valid and sets
// round_count to 10; the key table is not cleared and must be written.
module aes_block_cipher_top import aes_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = MaxRoundsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // {block_lo[63:0], block_hi[63:0], key_word[31:0], key_index[5:0]} from bit 0
  // up: key_index, key_word, block_hi, block_lo; padded to 168 bits
  input  logic [167:0] s_axis_tdata,
  // op
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_hi, result_lo
  output logic [127:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned KW = 4 * (MAX_ROUNDS + 1);
  localparam int unsigned GW = $clog2(MAX_ROUNDS + 1);
  localparam logic [1:0] REG_ROUNDS = 2'd0;

  logic [3:0]    rc_q;
  aes_cmd_t      cmd;
  logic [GW-1:0] raddr;
  logic          key_we;
  logic [127:0]  res;
  logic [5:0]    kidx;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ROUNDS) ? {28'd0, rc_q} : 32'd0;

  // round count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rc_q <= 4'd10;
    else if (psel && penable && pwrite && paddr == REG_ROUNDS) rc_q <= pwdata[3:0];
  end

  assign kidx   = s_axis_tdata[5:0];
  assign key_we = s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_KEY
                  && 32'(kidx) < 32'(KW);

  aes_ctrl #(.MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .op_i(s_axis_tuser), .round_count_i(rc_q),
    .cmd_o(cmd), .key_raddr_o(raddr),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready)
  );

  aes_datapath #(.MAX_ROUNDS(MAX_ROUNDS)) u_dp (
    .clk_i, .cmd_i(cmd), .key_we_i(key_we),
    .key_waddr_i(kidx[$clog2(KW)-1:0]), .key_wdata_i(s_axis_tdata[37:6]),
    .key_raddr_i(raddr),
    .block_i({s_axis_tdata[101:38], s_axis_tdata[165:102]}),
    .res_o(res)
  );

  assign m_axis_tdata = {res[63:0], res[127:64]};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import aes_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  idx;
    logic [31:0] word;
    logic [63:0] hi;
    logic [63:0] lo;
  } aes_beat_t;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  // key_index, key_word, block_hi, block_lo
  logic [167:0]  s_axis_tdata;
  // op
  logic [1:0]    s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  // result_hi, result_lo
  logic [127:0]  m_axis_tdata;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [1:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  aes_beat_t     beat_queue[$];
  logic [127:0]  block_queue[$];
  aes_beat_t     cur_beat;
  logic [31:0]   key_words [64];
  logic [3:0]    round_reg;
  logic [7:0]    sb_fwd [256];
  logic [7:0]    sb_inv [256];
  int            send_gap;
  int            recv_gap;
  bit            quiet;
  int            errors;
  int            cycles;

  aes_block_cipher_top i_dut (.*);

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // Build both S-boxes from the field inverse and the affine map
  function automatic void build_sboxes();
    logic [7:0] inv;
    logic [7:0] y;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int e = 0; e < 254; e++) inv = gf_mul(inv, x[7:0]);
      if (x == 0) inv = 8'h00;
      y = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
      sb_fwd[x] = y;
      sb_inv[y] = x[7:0];
    end
  endfunction

  function automatic logic [127:0] xor_key(logic [127:0] v, int rk);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        v[127 - 8 * (c * 4 + r) -: 8] ^= key_words[rk * 4 + c][31 - 8 * r -: 8];
    return v;
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] v, bit dec);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (dec)
          t[127 - 8 * (((c + r) & 3) * 4 + r) -: 8] = sb_inv[v[127 - 8 * (c * 4 + r) -: 8]];
        else
          t[127 - 8 * (c * 4 + r) -: 8] = sb_fwd[v[127 - 8 * (((c + r) & 3) * 4 + r) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] col_mix(logic [127:0] v, bit dec);
    logic [7:0] m [4];
    logic [7:0] s [4];
    logic [7:0] acc;
    if (dec) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) s[r] = v[127 - 8 * (c * 4 + r) -: 8];
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= gf_mul(m[(k + 4 - r) & 3], s[k]);
        v[127 - 8 * (c * 4 + r) -: 8] = acc;
      end
    end
    return v;
  endfunction

  // Full cipher over the tracked key table; returns {hi, lo}
  function automatic logic [127:0] cipher_model(logic [1:0] op, logic [63:0] hi,
                                                logic [63:0] lo);
    logic [127:0] v;
    int nr;
    v = {hi, lo};
    nr = (round_reg < MinRounds) ? MinRounds :
         (round_reg > MaxRoundsDefault) ? MaxRoundsDefault : round_reg;
    if (op == OP_ENC) begin
      v = xor_key(v, 0);
      for (int r = 1; r < nr; r++)
        v = xor_key(col_mix(sub_shift(v, 1'b0), 1'b0), r);
      v = xor_key(sub_shift(v, 1'b0), nr);
    end else begin
      v = xor_key(v, nr);
      for (int r = nr - 1; r > 0; r--)
        v = col_mix(xor_key(sub_shift(v, 1'b1), r), 1'b1);
      v = xor_key(sub_shift(v, 1'b1), 0);
    end
    return v;
  endfunction

  // Driver: present queued beats, predict on accept
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_beat.op == OP_KEY) begin
          if (cur_beat.idx < 60) key_words[cur_beat.idx] = cur_beat.word;
        end else if (cur_beat.op != OP_NOP) begin
          block_queue.push_back(cipher_model(cur_beat.op, cur_beat.hi, cur_beat.lo));
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (beat_queue.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap      <= $urandom_range(0, 5);
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_beat = beat_queue.pop_front();
          s_axis_tdata  <= {2'b0, cur_beat.lo, cur_beat.hi, cur_beat.word, cur_beat.idx};
          s_axis_tuser  <= cur_beat.op;
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each result beat
  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
      errors        <= 0;
      cycles        <= 0;
    end else begin
      cycles <= cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (block_queue.size() == 0) begin
          if (errors < 10) $display("unexpected result beat %h", m_axis_tdata);
          errors <= errors + 1;
        end else begin
          want = block_queue.pop_front();
          if (m_axis_tdata[63:0] !== want[127:64] || m_axis_tdata[127:64] !== want[63:0]) begin
            if (errors < 10)
              $display("block mismatch: hi exp %h got %h, lo exp %h got %h",
                       want[127:64], m_axis_tdata[63:0], want[63:0], m_axis_tdata[127:64]);
            errors <= errors + 1;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap      <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap      <= $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Hold until every beat is sent and every block has returned
  task automatic wait_drained();
    while (beat_queue.size() != 0 || s_axis_tvalid || block_queue.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_rounds(logic [3:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'd0;
    pwdata  <= {28'($urandom_range(0, 32'h0fff_ffff)), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel      <= 1'b0;
    penable   <= 1'b0;
    round_reg = value;
  endtask

  task automatic queue_beat(logic [1:0] op, logic [5:0] idx, logic [31:0] word,
                            logic [63:0] hi, logic [63:0] lo);
    aes_beat_t b;
    b.op   = op;
    b.idx  = idx;
    b.word = word;
    b.hi   = hi;
    b.lo   = lo;
    beat_queue.push_back(b);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly cipher blocks, some key updates, a few unused-op beats
  task automatic queue_random(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 5)
        queue_beat(OP_KEY, 6'($urandom_range(0, 63)), $urandom, rand64(), rand64());
      else if (pick == 5)
        queue_beat(OP_NOP, 6'($urandom_range(0, 63)), $urandom, rand64(), rand64());
      else
        queue_beat(pick[0] ? OP_ENC : OP_DEC, 6'($urandom_range(0, 63)), $urandom,
                   rand64(), rand64());
    end
  endtask

  // Watchdog
  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [3:0] settings [7];
    settings = '{4'd12, 4'd14, 4'd11, 4'd13, 4'd0, 4'd15, 4'd10};
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    round_reg = 4'd10;
    quiet     = 1'b0;
    build_sboxes();
    for (int i = 0; i < 64; i++) key_words[i] = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill the whole table, extremes at both ends, then out-of-range writes
    queue_beat(OP_KEY, 6'd0, 32'h0000_0000, '0, '0);
    for (int i = 1; i < 59; i++) queue_beat(OP_KEY, 6'(i), $urandom, rand64(), rand64());
    queue_beat(OP_KEY, 6'd59, 32'hffff_ffff, '1, '1);
    for (int i = 60; i < 64; i++) queue_beat(OP_KEY, 6'(i), $urandom, rand64(), rand64());
    // Directed blocks at the field extremes, plus the unused op
    queue_beat(OP_ENC, '0, '0, 64'h0, 64'h0);
    queue_beat(OP_DEC, '0, '0, 64'h0, 64'h0);
    queue_beat(OP_ENC, '1, '1, '1, '1);
    queue_beat(OP_DEC, '1, '1, '1, '1);
    queue_beat(OP_ENC, '0, '0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    queue_beat(OP_DEC, '0, '0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    queue_beat(OP_NOP, '1, '1, '1, '1);
    queue_random(60);
    wait_drained();

    // Step through round settings, including out-of-range values
    foreach (settings[s]) begin
      write_rounds(settings[s]);
      if (s == 6) quiet = 1'b1;
      queue_random(60);
      wait_drained();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
